FILE: hw/rtl/jse_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_B     = 8'h62;
	localparam logic [7:0] CH_LOW_F     = 8'h66;
	localparam logic [7:0] CH_LOW_N     = 8'h6E;
	localparam logic [7:0] CH_LOW_R     = 8'h72;
	localparam logic [7:0] CH_LOW_T     = 8'h74;
	localparam logic [7:0] CH_LOW_U     = 8'h75;

	localparam int JOB_LEN_W = 3;

	// one queued job: a plain byte, a two-byte escape, a \u00XX escape or the terminator
	typedef enum logic [1:0] {
		JOB_CHAR,
		JOB_SHORT,
		JOB_UNI,
		JOB_END
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data; // CHAR/UNI: source byte, SHORT: escape letter, END: unused
	} job_t;

	localparam logic [7:0] HEX_LOWER [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return HEX_LOWER[nib];
	endfunction

	function automatic logic [JOB_LEN_W-1:0] job_len(input job_kind_t kind);
		logic [JOB_LEN_W-1:0] len;
		unique case (kind)
			JOB_CHAR:  len = JOB_LEN_W'(1);
			JOB_SHORT: len = JOB_LEN_W'(2);
			JOB_UNI:   len = JOB_LEN_W'(6);
			JOB_END:   len = JOB_LEN_W'(1);
			default:   len = JOB_LEN_W'(1);
		endcase
		return len;
	endfunction

endpackage

FILE: hw/rtl/jse_front.sv
// Front end: takes source bytes, classifies them, tracks the byte budget, queues jobs.
`timescale 1ns / 1ps

module jse_front import jse_pkg::*; #(
	parameter int MAX_CAPACITY = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	input  logic [7:0] in_char,
	input  logic       q_full,
	output logic       in_ready,
	output logic       push,
	output job_t       push_job
);

	localparam logic [7:0] CAP_LIMIT = (MAX_CAPACITY > 255) ? 8'd255 : 8'(MAX_CAPACITY);

	logic [7:0] capacity_q;
	logic [7:0] count_q;
	logic       stopped_q;

	logic [7:0]           cap;
	logic                 take;
	job_t                 job;
	logic [JOB_LEN_W-1:0] len;
	logic [8:0]           sum;
	logic                 fits;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign cap      = (capacity_q > CAP_LIMIT) ? CAP_LIMIT : capacity_q;

	always_comb begin
		job.data = in_char;
		unique case (in_char)
			CH_NUL: begin
				job.kind = JOB_END;
			end
			CH_QUOTE, CH_BACKSLASH: begin
				job.kind = JOB_SHORT;
			end
			CH_LF: begin
				job.kind = JOB_SHORT;
				job.data = CH_LOW_N;
			end
			CH_CR: begin
				job.kind = JOB_SHORT;
				job.data = CH_LOW_R;
			end
			CH_TAB: begin
				job.kind = JOB_SHORT;
				job.data = CH_LOW_T;
			end
			CH_BS: begin
				job.kind = JOB_SHORT;
				job.data = CH_LOW_B;
			end
			CH_FF: begin
				job.kind = JOB_SHORT;
				job.data = CH_LOW_F;
			end
			default: begin
				job.kind = (in_char < CH_SPACE) ? JOB_UNI : JOB_CHAR;
			end
		endcase
	end

	assign len  = job_len(job.kind);
	assign sum  = {1'b0, count_q} + 9'(len);
	assign fits = (sum <= {1'b0, cap});

	assign push_job = job;
	assign push     = take && ((job.kind == JOB_END) || (!stopped_q && fits));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 8'd159;
			count_q    <= '0;
			stopped_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (take) begin
				if (job.kind == JOB_END) begin
					count_q   <= '0;
					stopped_q <= 1'b0;
				end else if (!stopped_q) begin
					if (fits) begin
						count_q <= sum[7:0];
					end else begin
						stopped_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

FILE: hw/rtl/jse_fifo.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module jse_fifo import jse_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/jse_back.sv
// Back end: expands one queued job into its output words, one word per cycle while out_ready is high.
`timescale 1ns / 1ps

module jse_back import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_end
);

	job_t                 cur_q;
	logic                 cur_valid_q;
	logic [JOB_LEN_W-1:0] idx_q;

	logic take;
	logic last;

	assign last      = (idx_q == job_len(cur_q.kind) - 1'b1);
	assign take      = cur_valid_q && out_ready;
	assign pop       = (!cur_valid_q || (take && last)) && !q_empty;
	assign out_valid = cur_valid_q;
	assign out_last  = last;
	assign out_end   = (cur_q.kind == JOB_END);

	always_comb begin
		unique case (cur_q.kind)
			JOB_CHAR: out_byte = cur_q.data;
			JOB_END:  out_byte = CH_NUL;
			JOB_SHORT: begin
				out_byte = (idx_q == '0) ? CH_BACKSLASH : cur_q.data;
			end
			JOB_UNI: begin
				case (idx_q)
					JOB_LEN_W'(0): out_byte = CH_BACKSLASH;
					JOB_LEN_W'(1): out_byte = CH_LOW_U;
					JOB_LEN_W'(4): out_byte = hex_digit(cur_q.data[7:4]);
					JOB_LEN_W'(5): out_byte = hex_digit(cur_q.data[3:0]);
					default:       out_byte = CH_ZERO;
				endcase
			end
			default: out_byte = CH_NUL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (take && last) begin
				cur_valid_q <= 1'b0;
			end else if (take) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/json_string_escaper.sv
// Top level of the JSON string escaper.
`timescale 1ns / 1ps

// Escapes a byte stream for use inside a JSON string. One source byte is
// accepted per cycle while the four-entry job queue has room; the output side
// sends one word per cycle while m_tready is high, and input keeps flowing
// into the queue while escapes drain. Quote, backslash and the common control
// bytes get short escapes, other bytes below 0x20 get \u00XX in lower-case
// hex. Each string may emit at most min(capacity, MAX_CAPACITY) bytes; the
// first byte whose output does not fit is dropped along with the rest of the
// string. A zero byte emits the terminator (tuser set) and starts a new
// string. m_tlast marks the last word produced by each source byte. capacity
// resets to 159 and is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, the block itself does not enforce this.
module json_string_escaper import jse_pkg::*; #(
	parameter int MAX_CAPACITY = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,  // capacity
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] char_in
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tlast,    // run_last
	output logic       m_tuser     // [0] string_end
);

	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic q_empty;
	logic q_full;

	jse_front #(
		.MAX_CAPACITY(MAX_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_char  (s_tdata),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_job (push_job)
	);

	jse_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast),
		.out_end  (m_tuser)
	);

endmodule

FILE: hw/rtl/jse_checker.sv
// Port-level checks for the JSON string escaper, bound to the top level.
`timescale 1ns / 1ps

module jse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// the terminator is always a single zero word closing its run
	a_end_is_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
		else $error("terminator word malformed");

	// escaping never lets a zero byte through except as the terminator
	a_zero_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == 8'h00) |-> m_tuser)
		else $error("zero word outside terminator");

	// an escape sequence is sent without gaps
	a_escape_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside escape sequence");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

FILE: tb/json_string_escaper_check.sv
// Checker for the JSON string escaper: predicts the escaped byte stream and compares it.
`timescale 1ns / 1ps

module json_string_escaper_check import jse_pkg::*; #(
	parameter int MAX_CAPACITY = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic       m_tuser,
	output int         mismatches,
	output int         words_owed
);

	localparam logic [7:0] CH_LOW_A = 8'h61;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       term;
	} esc_word_t;

	esc_word_t  escaped_words[$];
	logic [7:0] capacity;
	logic [7:0] bytes_used;
	logic       halted;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return CH_ZERO + 8'(nib);
		return CH_LOW_A + 8'(nib - 4'd10);
	endfunction

	// queues the escaped form of one source byte and advances the string state
	task automatic escape_byte(input logic [7:0] c);
		logic [7:0] seq [6];
		int         n;
		int         room;
		room = (int'(capacity) > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity);
		if (c == CH_NUL) begin
			escaped_words.push_back('{ch: CH_NUL, last: 1'b1, term: 1'b1});
			bytes_used = 8'd0;
			halted = 1'b0;
			return;
		end
		if (halted)
			return;
		n = 2;
		seq[0] = CH_BACKSLASH;
		case (c)
			CH_QUOTE:     seq[1] = CH_QUOTE;
			CH_BACKSLASH: seq[1] = CH_BACKSLASH;
			CH_LF:        seq[1] = CH_LOW_N;
			CH_CR:        seq[1] = CH_LOW_R;
			CH_TAB:       seq[1] = CH_LOW_T;
			CH_BS:        seq[1] = CH_LOW_B;
			CH_FF:        seq[1] = CH_LOW_F;
			default: begin
				if (c < CH_SPACE) begin
					n = 6;
					seq[1] = CH_LOW_U;
					seq[2] = CH_ZERO;
					seq[3] = CH_ZERO;
					seq[4] = hex_char(c[7:4]);
					seq[5] = hex_char(c[3:0]);
				end else begin
					n = 1;
					seq[0] = c;
				end
			end
		endcase
		// a plain byte or escape that does not fit whole kills the rest of the string
		if (int'(bytes_used) + n > room) begin
			halted = 1'b1;
			return;
		end
		for (int i = 0; i < n; i++)
			escaped_words.push_back('{ch: seq[i], last: (i == n - 1), term: 1'b0});
		bytes_used = bytes_used + 8'(n);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		esc_word_t want;
		if (!arst_n) begin
			capacity = 8'd159;
			bytes_used = 8'd0;
			halted = 1'b0;
			escaped_words.delete();
			mismatches = 0;
			words_owed = 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (s_tvalid && s_tready)
				escape_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (escaped_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: byte %h last %b end %b",
							m_tdata, m_tlast, m_tuser);
				end else begin
					want = escaped_words.pop_front();
					if (m_tdata !== want.ch || m_tlast !== want.last
							|| m_tuser !== want.term) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch: expected %h/%b/%b, got %h/%b/%b",
								want.ch, want.last, want.term, m_tdata, m_tlast, m_tuser);
					end
				end
			end
			words_owed = escaped_words.size();
		end
	end

endmodule

FILE: tb/json_string_escaper_test.sv
// Testbench top for the JSON string escaper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module json_string_escaper_test;
	import jse_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;
	logic       calm = 1'b0;
	int         mismatches;
	int         words_owed;
	int         cycles = 0;

	json_string_escaper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	json_string_escaper_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.words_owed (words_owed)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 15);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c);
		while (!calm && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every owed word drain, plus slack for dropped bytes
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [7:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] shorts [7];
		shorts = '{CH_QUOTE, CH_BACKSLASH, CH_LF, CH_CR, CH_TAB, CH_BS, CH_FF};
		case ($urandom_range(0, 9))
			0, 1:    return shorts[$urandom_range(0, 6)];
			2:       return 8'($urandom_range(1, 8'h1F));
			3, 4:    return 8'($urandom_range(8'h80, 8'hFF));
			default: return 8'($urandom_range(8'h20, 8'h7F));
		endcase
	endfunction

	// strings of random content, mostly terminated
	task automatic random_strings(input int budget);
		int len;
		while (budget > 0) begin
			len = $urandom_range(1, 10);
			repeat (len) send_char(pick_char());
			budget -= len;
			if ($urandom_range(0, 5) != 0) begin
				send_char(CH_NUL);
				budget--;
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] script[$];
		logic [7:0] caps[$];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every escape class at reset capacity
		script = '{CH_QUOTE, CH_BACKSLASH, CH_LF, CH_CR, CH_TAB, CH_BS, CH_FF,
			8'h01, 8'h1F, CH_SPACE, 8'h7F, 8'h80, 8'hFF, CH_NUL};
		foreach (script[i]) send_char(script[i]);

		// zero capacity: only the terminator gets out
		set_capacity(8'd0);
		script = '{8'h61, 8'h01, CH_NUL};
		foreach (script[i]) send_char(script[i]);

		// tight capacity: unicode escape has no room, then exact fit of a short escape
		set_capacity(8'd3);
		script = '{8'h61, 8'h62, 8'h01, 8'h63, CH_NUL, 8'h61, CH_QUOTE, 8'h62, CH_NUL};
		foreach (script[i]) send_char(script[i]);

		// full capacity, no idling: a long run of unicode escapes overflows 255
		set_capacity(8'd255);
		calm = 1'b1;
		repeat (50) send_char(8'($urandom_range(8'h0E, 8'h1F)));
		send_char(CH_NUL);
		calm = 1'b0;
		random_strings(9);

		caps = '{8'd1, 8'd2, 8'd6, 8'd7, 8'($urandom_range(0, 255)), 8'd0, 8'd159};
		foreach (caps[i]) begin
			set_capacity(caps[i]);
			random_strings(9);
		end

		settle();
		if (mismatches == 0 && words_owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_fifo.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper.sv
hw/rtl/jse_checker.sv
tb/json_string_escaper_check.sv
tb/json_string_escaper_test.sv
